/* hw/rtl/b64d_pkg.sv */
// Shared types, constants and the character classifier of the base64 decoder.
package b64d_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

	// Value returned for any character outside the alphabet.
	localparam logic [6:0] SEXTET_NONE = 7'd64;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_message;
	} out_t;

	// Work handed from the front to the back: up to three bytes and an end mark.
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [1:0] nbytes;
		logic       eom;
	} job_t;

	function automatic logic [6:0] sextet(input logic [7:0] c);
		logic [6:0] v;
		v = SEXTET_NONE;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
			v = 7'(c - CHAR_UPPER_A);
		else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
			v = 7'(c - CHAR_LOWER_A + 8'd26);
		else if (c >= CHAR_ZERO && c <= CHAR_NINE)
			v = 7'(c - CHAR_ZERO + 8'd52);
		else if (c == CHAR_PLUS)
			v = 7'd62;
		else if (c == CHAR_SLASH)
			v = 7'd63;
		return v;
	endfunction

endpackage

/* hw/rtl/base64_decoder.sv */
// Streaming base64 decoder: top level joining front end, job queue and back end.
//
//   channel   handshake        payload   meaning
//   input     push / full      code      one character, flag on the final one
//   output    pop / empty      result    one decoded byte or a bare end mark
//
// A character is accepted in any cycle while full is low, one per cycle.
// Each item yields at most one job of up to three bytes; the back end releases
// one result per cycle while pop is high, so four characters in give three results out in step.
// full rises only when the job queue (QUEUE_DEPTH entries) is full.
// Reset clears the group state, the queue and the back end; no results remain.
module base64_decoder #(
	parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  b64d_pkg::in_t  code,
	output logic           empty,
	input  logic           pop,
	output b64d_pkg::out_t result
);

	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;
	b64d_pkg::job_t wr_job;
	b64d_pkg::job_t rd_job;

	b64d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.code   (code),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (wr_job)
	);

	b64d_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_job (wr_job),
		.full   (q_full),
		.rd     (q_pop),
		.rd_job (rd_job),
		.empty  (q_empty)
	);

	b64d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_job   (rd_job),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

/* hw/rtl/b64d_front.sv */
// Front end: accepts characters, keeps the group state and forms byte jobs.
module b64d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  b64d_pkg::in_t     code,
	input  logic              q_full,
	output logic              q_push,
	output b64d_pkg::job_t    q_job
);

	logic [17:0] acc_q;
	logic [1:0]  cnt_q;
	logic        stopped_q;

	logic        accept;
	logic [6:0]  sx;
	logic        is_alpha;
	logic        take;
	logic        complete;
	logic        flush;
	logic [17:0] acc_n;
	logic [1:0]  cnt_n;
	logic [17:0] acc_f;
	logic [1:0]  cnt_f;

	assign full   = q_full;
	assign accept = push && !q_full;

	assign sx       = b64d_pkg::sextet(code.in_char);
	assign is_alpha = !sx[6];
	assign take     = !stopped_q && is_alpha;
	assign complete = take && (cnt_q == 2'd3);
	assign flush    = (!stopped_q && !is_alpha) || code.in_last;
	assign acc_n    = {acc_q[11:0], sx[5:0]};
	assign cnt_n    = cnt_q + 2'd1;

	// A final item flushes the group as it stands after this character is added.
	assign acc_f = (take && !complete) ? acc_n : acc_q;
	assign cnt_f = (take && !complete) ? cnt_n : cnt_q;

	always_comb begin
		q_job        = '0;
		q_job.eom    = code.in_last;
		if (complete) begin
			q_job.byte0  = acc_q[17:10];
			q_job.byte1  = acc_q[9:2];
			q_job.byte2  = {acc_q[1:0], sx[5:0]};
			q_job.nbytes = 2'd3;
		end else if (flush) begin
			case (cnt_f)
				2'd2: begin
					q_job.byte0  = acc_f[11:4];
					q_job.nbytes = 2'd1;
				end
				2'd3: begin
					q_job.byte0  = acc_f[17:10];
					q_job.byte1  = acc_f[9:2];
					q_job.nbytes = 2'd2;
				end
				default: q_job.nbytes = 2'd0;
			endcase
		end
	end

	assign q_push = accept && ((q_job.nbytes != 2'd0) || code.in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			cnt_q     <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (code.in_last || complete) begin
				acc_q     <= '0;
				cnt_q     <= '0;
				stopped_q <= 1'b0;
			end else if (take) begin
				acc_q <= acc_n;
				cnt_q <= cnt_n;
			end else if (!stopped_q) begin
				acc_q     <= '0;
				cnt_q     <= '0;
				stopped_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// A job without bytes exists only to carry the end mark.
	a_empty_job_has_eom: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_job.nbytes == 2'd0) |-> q_job.eom)
		else $error("empty job pushed without end mark");
	// Once stopped, the group state stays cleared.
	a_stopped_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (cnt_q == 2'd0 && acc_q == '0))
		else $error("group state not clear while stopped");
`endif

endmodule

/* hw/rtl/b64d_fifo.sv */
// Short job queue between the front end and the back end.
module b64d_fifo #(
	parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  b64d_pkg::job_t wr_job,
	output logic           full,
	input  logic           rd,
	output b64d_pkg::job_t rd_job,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64d_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_job = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			if (do_rd)
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

/* hw/rtl/b64d_back.sv */
// Back end: holds one job and releases its bytes as result items, one per pop.
module b64d_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  b64d_pkg::job_t q_job,
	output logic           q_pop,
	output logic           empty,
	input  logic           pop,
	output b64d_pkg::out_t result
);

	b64d_pkg::job_t cur_q;
	logic           busy_q;
	logic [1:0]     idx_q;
	logic           last_of_job;
	logic           taken;

	assign empty       = !busy_q;
	assign taken       = pop && busy_q;
	assign last_of_job = (cur_q.nbytes == 2'd0) || (idx_q == cur_q.nbytes - 2'd1);
	// The next job is loaded in the same cycle the previous one finishes.
	assign q_pop       = !q_empty && (!busy_q || (taken && last_of_job));

	always_comb begin
		result                = '0;
		result.byte_valid     = (cur_q.nbytes != 2'd0);
		result.end_of_message = cur_q.eom && last_of_job;
		if (cur_q.nbytes != 2'd0) begin
			case (idx_q)
				2'd0:    result.out_byte = cur_q.byte0;
				2'd1:    result.out_byte = cur_q.byte1;
				default: result.out_byte = cur_q.byte2;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (taken) begin
			if (last_of_job)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_bare_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.byte_valid) |-> result.end_of_message)
		else $error("result without byte and without end mark");
	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cur_q.nbytes != 2'd0) |-> (idx_q < cur_q.nbytes))
		else $error("byte index beyond job length");
`endif

endmodule

/* verif/base64_decoder_test.sv */
// Self-checking testbench of the streaming base64 decoder, with an item-level scoreboard.
module base64_decoder_test;

	localparam string ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam logic [7:0] CHAR_PAD = 8'h3D;
	localparam int RANDOM_ITEMS = 235;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 20;
	// Longest legal stretch without a handshake is the long receiver hold-off;
	// random idles add only a few cycles on top, so this leaves a wide margin.
	localparam int STALL_LIMIT  = 2000;

	// Mirrors the decoder: group state, stop flag and the bytes still owed.
	class b64_scoreboard;
		b64d_pkg::out_t pending_bytes[$];
		logic [6:0]     sextet_tbl[256];
		logic [17:0]    acc;
		logic [1:0]     cnt;
		logic           stopped;
		int             failures;

		function new();
			for (int i = 0; i < 256; i++)
				sextet_tbl[i] = b64d_pkg::SEXTET_NONE;
			for (int i = 0; i < 64; i++)
				sextet_tbl[ALPHABET[i]] = 7'(i);
			acc = '0;
			cnt = '0;
			stopped = 1'b0;
			failures = 0;
		endfunction

		function void owe_byte(logic [7:0] b);
			pending_bytes.push_back('{out_byte: b, byte_valid: 1'b1, end_of_message: 1'b0});
		endfunction

		// A partial group of n characters yields n-1 bytes.
		function void flush_group();
			if (cnt == 2'd2) begin
				owe_byte(acc[11:4]);
			end else if (cnt == 2'd3) begin
				owe_byte(acc[17:10]);
				owe_byte(acc[9:2]);
			end
			acc = '0;
			cnt = '0;
		endfunction

		function void note_char(b64d_pkg::in_t it);
			int             owed_at_start;
			logic [6:0]     v;
			logic [23:0]    word;
			b64d_pkg::out_t tail;
			owed_at_start = pending_bytes.size();
			if (!stopped) begin
				v = sextet_tbl[it.in_char];
				if (v == b64d_pkg::SEXTET_NONE) begin
					flush_group();
					stopped = 1'b1;
				end else if (cnt == 2'd3) begin
					word = {acc, v[5:0]};
					owe_byte(word[23:16]);
					owe_byte(word[15:8]);
					owe_byte(word[7:0]);
					acc = '0;
					cnt = '0;
				end else begin
					acc = {acc[11:0], v[5:0]};
					cnt = cnt + 2'd1;
				end
			end
			if (it.in_last) begin
				flush_group();
				if (pending_bytes.size() == owed_at_start) begin
					pending_bytes.push_back('{out_byte: 8'h00, byte_valid: 1'b0,
						end_of_message: 1'b1});
				end else begin
					tail = pending_bytes.pop_back();
					tail.end_of_message = 1'b1;
					pending_bytes.push_back(tail);
				end
				stopped = 1'b0;
			end
		endfunction

		function void check_result(b64d_pkg::out_t got);
			b64d_pkg::out_t want;
			bit             bad;
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected result, actual byte=%h valid=%b eom=%b",
					$time, got.out_byte, got.byte_valid, got.end_of_message);
				failures++;
				return;
			end
			want = pending_bytes.pop_front();
			bad = 1'b0;
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %h actual %h",
					$time, want.out_byte, got.out_byte);
				bad = 1'b1;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$display("%0t: byte_valid expected %b actual %b",
					$time, want.byte_valid, got.byte_valid);
				bad = 1'b1;
			end
			if (got.end_of_message !== want.end_of_message) begin
				$display("%0t: end_of_message expected %b actual %b",
					$time, want.end_of_message, got.end_of_message);
				bad = 1'b1;
			end
			if (bad)
				failures++;
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           push;
	logic           full;
	b64d_pkg::in_t  code;
	logic           empty;
	logic           pop;
	b64d_pkg::out_t result;

	b64_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  items_sent;
	bit  hold_req;
	int  hold_left;

	base64_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.code   (code),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: takes results at random, or holds off entirely when asked.
	always @(posedge clk) begin
		if (pop && !empty)
			sb.check_result(result);
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Ends the run if no item moves on either side for too long.
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stall = 0;
			else
				stall++;
		end
		$display("base64_decoder: mismatch");
		$finish;
	end

	task automatic send_item(logic [7:0] c, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		code <= '{in_char: c, in_last: last};
		do
			@(posedge clk);
		while (full);
		sb.note_char('{in_char: c, in_last: last});
		items_sent++;
	endtask

	task automatic send_message(logic [7:0] msg[$]);
		foreach (msg[i])
			send_item(msg[i], i == msg.size() - 1);
	endtask

	task automatic send_text(string s);
		logic [7:0] msg[$];
		for (int i = 0; i < s.len(); i++)
			msg.push_back(s[i]);
		send_message(msg);
	endtask

	function automatic logic [7:0] any_alpha();
		return ALPHABET[$urandom_range(63)];
	endfunction

	// Mostly well-formed messages with optional padding; the rest is noise.
	task automatic send_random_message();
		logic [7:0] msg[$];
		int         tail;
		if ($urandom_range(99) < 70) begin
			repeat (4 * $urandom_range(0, 4))
				msg.push_back(any_alpha());
			tail = $urandom_range(0, 3);
			repeat (tail)
				msg.push_back(any_alpha());
			if (tail >= 2 && $urandom_range(3) != 0) begin
				repeat (4 - tail)
					msg.push_back(CHAR_PAD);
			end
			if ($urandom_range(4) == 0) begin
				repeat ($urandom_range(1, 3))
					msg.push_back(8'($urandom_range(255)));
			end
			if (msg.size() == 0)
				msg.push_back(any_alpha());
		end else begin
			repeat ($urandom_range(1, 10)) begin
				if ($urandom_range(1) == 0)
					msg.push_back(8'($urandom_range(255)));
				else
					msg.push_back(any_alpha());
			end
		end
		send_message(msg);
	endtask

	initial begin
		bit held;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		code = '0;
		items_sent = 0;
		hold_req = 1'b0;
		hold_left = 0;
		held = 1'b0;
		send_idle_pct = 29;
		recv_idle_pct = 81;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full group on the final item, then a padded single-byte tail.
		send_text("TWFu");
		send_text("TQ==");
		// A lone leftover character and a lone terminator give bare end marks.
		send_text("Q");
		send_message('{8'h00});
		// Alphabet extremes across two groups.
		send_text("AZaz09+/");
		// Characters after a stop are ignored; the final one only carries the end mark.
		send_message('{"A", "B", 8'hFF, "C", "D"});
		// Terminator on the final item flushes a three-character group.
		send_message('{"A", "B", "C", 8'h80});

		while (items_sent < 27 + RANDOM_ITEMS) begin
			if (items_sent < 27 + RANDOM_ITEMS / 3) begin
				send_idle_pct = 29;
				recv_idle_pct = 81;
			end else if (items_sent < 27 + 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 81;
				recv_idle_pct = 29;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				if (!held) begin
					hold_req = 1'b1;
					held = 1'b1;
				end
			end
			send_random_message();
		end
		push <= 1'b0;

		while (sb.pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("base64_decoder: match");
		else
			$display("base64_decoder: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_fifo.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_decoder.sv
verif/base64_decoder_test.sv
